/* sv/polynomial_waveshaper_mix_dither_assert.svh */
// ----------------------------------------------------------------------------
// polynomial_waveshaper_mix_dither_assert.svh
// Assertion macros for the waveshaper checker.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_WAVESHAPER_MIX_DITHER_ASSERT_SVH
`define POLYNOMIAL_WAVESHAPER_MIX_DITHER_ASSERT_SVH

// Checked outside reset only.
`define PWMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define PWMD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* sv/pwmd_pkg.sv */
// ----------------------------------------------------------------------------
// pwmd_pkg
// Shared widths, register map, reset values and inter-module structs.
// ----------------------------------------------------------------------------
package pwmd_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int INTERNAL_BITS = 40;
  localparam int FRAC_BITS     = INTERNAL_BITS - 12;
  localparam int LSB_POS       = FRAC_BITS - (SAMPLE_BITS - 1);
  localparam int INT_W         = INTERNAL_BITS;
  localparam int T_W           = 32;
  localparam int MUL_W         = 36;
  localparam int SEED_W        = 32;
  localparam int SH_W          = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int TRIM_W     = 6;
  localparam int WGT_W      = 5;
  localparam int WET_W      = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIM  = 2'd0,
    REG_PLUS  = 2'd1,
    REG_MINUS = 2'd2,
    REG_WET   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TRIM_W-1:0] trim;
    logic [WGT_W-1:0]  plus;
    logic [WGT_W-1:0]  minus;
    logic [WET_W-1:0]  wet;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    trim:  TRIM_W'(1),
    plus:  WGT_W'(1),
    minus: WGT_W'(1),
    wet:   WET_W'(65536)
  };

  localparam logic [SEED_W-1:0] SEED_L_RST = 32'h12345678;
  localparam logic [SEED_W-1:0] SEED_R_RST = 32'h87654321;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
    logic             neg;
    logic [SH_W-1:0]  n;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [INT_W-1:0] res;
  } mul_rsp_t;

endpackage

/* sv/pwmd_if.sv */
// ----------------------------------------------------------------------------
// pwmd_if
// Valid/ready stereo frame channels for the waveshaper.
// ----------------------------------------------------------------------------
interface pwmd_in_if import pwmd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_in;
  logic [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface pwmd_out_if import pwmd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_out;
  logic [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

/* sv/pwmd_mul.sv */
// ----------------------------------------------------------------------------
// pwmd_mul
// Iterative 36x36 magnitude multiplier on one 36x18 array, with rounded
// right shift (half away from zero) and sign applied to the result.
// ----------------------------------------------------------------------------
module pwmd_mul import pwmd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int HALF_W = MUL_W / 2;
  localparam int PROD_W = MUL_W + HALF_W;
  localparam int ACC_W  = 2 * MUL_W;

  localparam logic [1:0] PH_HI  = 2'd0;
  localparam logic [1:0] PH_LO  = 2'd1;
  localparam logic [1:0] PH_ADD = 2'd2;
  localparam logic [1:0] PH_RND = 2'd3;

  logic              busy;
  logic [1:0]        ph;
  logic              done;
  logic [MUL_W-1:0]  a_r;
  logic [MUL_W-1:0]  b_r;
  logic              neg_r;
  logic [SH_W-1:0]   n_r;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;
  logic [INT_W-1:0]  res_r;

  logic [HALF_W-1:0] b_part;
  logic [ACC_W-1:0]  half;
  logic [ACC_W-1:0]  rsum;
  logic [ACC_W-1:0]  rmag;
  logic [INT_W-1:0]  rlo;
  logic [INT_W-1:0]  rval;

  assign b_part = ph[0] ? b_r[HALF_W-1:0] : b_r[MUL_W-1:HALF_W];

  always_comb begin
    half = ACC_W'(1) << (n_r - 1'b1);
    rsum = acc + half;
    rmag = rsum >> n_r;
    rlo  = rmag[INT_W-1:0];
    rval = neg_r ? (~rlo + 1'b1) : rlo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph   <= PH_HI;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        ph   <= PH_HI;
      end else if (busy) begin
        ph <= ph + 2'd1;
        if (ph == PH_RND) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      neg_r <= req.neg;
      n_r   <= req.n;
    end
    if (busy) begin
      case (ph)
        PH_HI: begin
          prod <= PROD_W'(a_r) * PROD_W'(b_part);
        end
        PH_LO: begin
          acc  <= ACC_W'(prod) << HALF_W;
          prod <= PROD_W'(a_r) * PROD_W'(b_part);
        end
        PH_ADD: begin
          acc <= acc + ACC_W'(prod);
        end
        default: begin
          res_r <= rval;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res_r;

endmodule

/* sv/pwmd_seq.sv */
// ----------------------------------------------------------------------------
// pwmd_seq
// Frame sequencer: trims, shapes, mixes, dithers and saturates the left and
// then the right sample, issuing all products to the shared multiplier.
// ----------------------------------------------------------------------------
module pwmd_seq import pwmd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] left_in,
  input  logic [SAMPLE_BITS-1:0] right_in,
  output logic                   idle,
  output logic                   res_valid,
  input  logic                   res_take,
  output logic [SAMPLE_BITS-1:0] res_left,
  output logic [SAMPLE_BITS-1:0] res_right
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_TRIM   = 12'b000000000010,
    ST_MUL    = 12'b000000000100,
    ST_WAIT   = 12'b000000001000,
    ST_POLY1  = 12'b000000010000,
    ST_POLY2  = 12'b000000100000,
    ST_WEIGH  = 12'b000001000000,
    ST_DIFF   = 12'b000010000000,
    ST_DITHER = 12'b000100000000,
    ST_ZSUM   = 12'b001000000000,
    ST_OUT    = 12'b010000000000,
    ST_DONE   = 12'b100000000000
  } state_t;

  typedef enum logic [1:0] {
    OP_SQ   = 2'd0,
    OP_CUBE = 2'd1,
    OP_QUAD = 2'd2,
    OP_MIX  = 2'd3
  } op_t;

  localparam logic signed [TRIM_W-1:0] TRIM_MIN = TRIM_W'(-2);
  localparam logic signed [TRIM_W-1:0] TRIM_OFF = TRIM_W'(17);
  localparam logic signed [TRIM_W-1:0] LSB_S    = TRIM_W'(LSB_POS);
  localparam logic [WGT_W-1:0]         WGT_OFF  = WGT_W'(17);
  localparam logic [WGT_W-1:0]         WGT_MIN  = WGT_W'(1);
  localparam logic [WET_W-1:0]         MIX_ONE  = WET_W'(65536);
  localparam logic [SH_W-1:0]          FRAC_SH  = SH_W'(FRAC_BITS);
  localparam logic [SH_W-1:0]          MIX_SH   = SH_W'(16);
  localparam logic [SH_W-1:0]          DITH_SH  = SH_W'(31 - LSB_POS);
  localparam logic [SH_W-1:0]          OUT_SH   = SH_W'(LSB_POS);
  localparam logic [SH_W-1:0]          P3_SH    = SH_W'(2);
  localparam logic [SH_W-1:0]          P24_SH   = SH_W'(4);
  localparam logic signed [INT_W-1:0]  DITHER_CENTER = INT_W'(64'h7fffffff);
  localparam logic signed [INT_W-1:0]  SAT_HI =
    INT_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [INT_W-1:0]  SAT_LO =
    INT_W'(-(longint'(1) << (SAMPLE_BITS - 1)));

  function automatic logic signed [INT_W-1:0] rnd_shr(
    input logic signed [INT_W-1:0] v,
    input logic [SH_W-1:0]         n
  );
    logic [INT_W-1:0] mag;
    logic [INT_W-1:0] half;
    logic [INT_W-1:0] r;
    mag  = v[INT_W-1] ? (~v + 1'b1) : v;
    half = (n == '0) ? '0 : (INT_W'(1) << (n - 1'b1));
    r    = (mag + half) >> n;
    return v[INT_W-1] ? $signed(~r + 1'b1) : $signed(r);
  endfunction

  function automatic logic signed [INT_W-1:0] weigh(
    input logic signed [INT_W-1:0] v,
    input logic [WGT_W-1:0]        code
  );
    logic [WGT_W-1:0] eff;
    eff = (code == '0) ? WGT_MIN : code;
    if (code >= WGT_OFF) begin
      return '0;
    end
    return rnd_shr(v, eff);
  endfunction

  function automatic logic [SEED_W-1:0] next_seed(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] r;
    r = s ^ (s << 13);
    r = r ^ (r >> 17);
    r = r ^ (r << 5);
    return r;
  endfunction

  state_t state;
  op_t    op;
  logic   ch;

  logic [SEED_W-1:0] seed_l;
  logic [SEED_W-1:0] seed_r;

  logic signed [SAMPLE_BITS-1:0] xl;
  logic signed [SAMPLE_BITS-1:0] xr;
  logic signed [T_W-1:0]         t;
  logic signed [INT_W-1:0]       t2;
  logic signed [INT_W-1:0]       t3;
  logic signed [INT_W-1:0]       t4;
  logic signed [INT_W-1:0]       pp;
  logic signed [INT_W-1:0]       mm;
  logic signed [INT_W-1:0]       acc;
  logic [SAMPLE_BITS-1:0]        res_l;
  logic [SAMPLE_BITS-1:0]        res_r;

  logic signed [SAMPLE_BITS-1:0] x_cur;
  logic signed [INT_W-1:0]       x_ext;
  logic signed [INT_W-1:0]       d;
  logic [SEED_W-1:0]             seed_cur;
  logic signed [TRIM_W-1:0]      trim_s;
  logic signed [TRIM_W-1:0]      trim_c;
  logic signed [TRIM_W-1:0]      tdiff;
  logic signed [TRIM_W-1:0]      tneg;
  logic signed [T_W-1:0]         t_next;
  logic [T_W-1:0]                t_mag;
  logic [INT_W-1:0]              pp_mag;
  logic [WET_W-1:0]              wet_c;
  logic signed [INT_W-1:0]       q;
  logic [SAMPLE_BITS-1:0]        q_sat;
  logic signed [INT_W-1:0]       mres;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  pwmd_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign x_cur    = ch ? xr : xl;
  assign x_ext    = INT_W'(x_cur);
  assign d        = x_ext <<< LSB_POS;
  assign seed_cur = ch ? seed_r : seed_l;
  assign t_mag    = t[T_W-1] ? (~t + 1'b1) : t;
  assign pp_mag   = pp[INT_W-1] ? (~pp + 1'b1) : pp;
  assign wet_c    = (cfg.wet > MIX_ONE) ? MIX_ONE : cfg.wet;
  assign mres     = $signed(mrsp.res);

  always_comb begin
    trim_s = $signed(cfg.trim);
    trim_c = (trim_s < TRIM_MIN) ? TRIM_MIN : trim_s;
    tdiff  = LSB_S - trim_c;
    tneg   = -tdiff;
    if (trim_c >= TRIM_OFF) begin
      t_next = '0;
    end else if (!tdiff[TRIM_W-1]) begin
      t_next = T_W'(x_ext <<< tdiff[2:0]);
    end else begin
      t_next = T_W'(rnd_shr(x_ext, tneg[SH_W-1:0]));
    end
  end

  always_comb begin
    q = rnd_shr(acc, OUT_SH);
    if (q > SAT_HI) begin
      q_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < SAT_LO) begin
      q_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      q_sat = q[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    mreq       = '0;
    mreq.start = (state == ST_MUL);
    mreq.n     = FRAC_SH;
    unique case (op)
      OP_SQ: begin
        mreq.a = MUL_W'(t_mag);
        mreq.b = MUL_W'(t_mag);
      end
      OP_CUBE: begin
        mreq.a   = t2[MUL_W-1:0];
        mreq.b   = MUL_W'(t_mag);
        mreq.neg = t[T_W-1];
      end
      OP_QUAD: begin
        mreq.a = t2[MUL_W-1:0];
        mreq.b = t2[MUL_W-1:0];
      end
      OP_MIX: begin
        mreq.a   = pp_mag[MUL_W-1:0];
        mreq.b   = MUL_W'(wet_c);
        mreq.neg = pp[INT_W-1];
        mreq.n   = MIX_SH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      op     <= OP_SQ;
      ch     <= 1'b0;
      seed_l <= SEED_L_RST;
      seed_r <= SEED_R_RST;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            ch    <= 1'b0;
            state <= ST_TRIM;
          end
        end
        ST_TRIM: begin
          op    <= OP_SQ;
          state <= ST_MUL;
          if (ch) begin
            seed_r <= next_seed(seed_r);
          end else begin
            seed_l <= next_seed(seed_l);
          end
        end
        ST_MUL: state <= ST_WAIT;
        ST_WAIT: begin
          if (mrsp.done) begin
            unique case (op)
              OP_SQ: begin
                op    <= OP_CUBE;
                state <= ST_MUL;
              end
              OP_CUBE: begin
                op    <= OP_QUAD;
                state <= ST_MUL;
              end
              OP_QUAD: state <= ST_POLY1;
              OP_MIX:  state <= ST_DITHER;
            endcase
          end
        end
        ST_POLY1: state <= ST_POLY2;
        ST_POLY2: state <= ST_WEIGH;
        ST_WEIGH: state <= ST_DIFF;
        ST_DIFF: begin
          op    <= OP_MIX;
          state <= ST_MUL;
        end
        ST_DITHER: state <= ST_ZSUM;
        ST_ZSUM:   state <= ST_OUT;
        ST_OUT: begin
          if (ch) begin
            state <= ST_DONE;
          end else begin
            ch    <= 1'b1;
            state <= ST_TRIM;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          xl <= left_in;
          xr <= right_in;
        end
      end
      ST_TRIM: t <= t_next;
      ST_WAIT: begin
        if (mrsp.done) begin
          unique case (op)
            OP_SQ:   t2  <= mres;
            OP_CUBE: t3  <= mres;
            OP_QUAD: t4  <= mres;
            OP_MIX:  acc <= d + mres;
          endcase
        end
      end
      ST_POLY1: begin
        pp <= (INT_W'(t) <<< 1) - t2;
        mm <= INT_W'(t) + rnd_shr(t3, P3_SH);
        t4 <= t2 + t4;
      end
      ST_POLY2:  mm <= mm - rnd_shr(t4, P24_SH);
      ST_WEIGH: begin
        pp <= weigh(pp, cfg.plus);
        mm <= weigh(mm, cfg.minus);
      end
      ST_DIFF:   pp <= pp + mm - d;
      ST_DITHER: pp <= rnd_shr($signed(INT_W'(seed_cur)) - DITHER_CENTER, DITH_SH);
      ST_ZSUM:   acc <= acc + pp;
      ST_OUT: begin
        if (ch) begin
          res_r <= q_sat;
        end else begin
          res_l <= q_sat;
        end
      end
      default: ;
    endcase
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res_left  = res_l;
  assign res_right = res_r;

endmodule

/* sv/polynomial_waveshaper_mix_dither.sv */
// ----------------------------------------------------------------------------
// polynomial_waveshaper_mix_dither
// Stereo polynomial waveshaper with wet/dry mix, dither and saturation.
//
// in_frame carries one stereo frame (left_in, right_in, signed Q1.23) per
// transaction; out_frame returns one processed frame per input frame, in
// order. Both are valid/ready channels.
// Registers (trim_shift, plus_shift, minus_shift, wet_mix) are written by
// cfg_we/cfg_index/cfg_data; the user must do so only while the block is
// idle (not enforced by the block); they take effect on the next frame.
// Each frame runs through one shared 36x18 multiplier: four products per
// channel, each issued, passed through the high-half, low-half, add and
// round phases of the multiplier and captured, with the left channel
// before the right. in_frame is ready again only once the frame is done
// and its result has moved into the output register.
// Output is registered: a finished frame waits there while the next frame
// is taken in. A stalled receiver holds out_frame; a second finished frame
// then waits inside and no further input is taken.
// Reset loads default registers and dither seeds and empties the output.
// ----------------------------------------------------------------------------
module polynomial_waveshaper_mix_dither import pwmd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pwmd_in_if.sink               in_frame,
  pwmd_out_if.source            out_frame
);

  cfg_t cfg;

  logic                   idle;
  logic                   start;
  logic                   res_valid;
  logic                   res_take;
  logic [SAMPLE_BITS-1:0] res_left;
  logic [SAMPLE_BITS-1:0] res_right;
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_left;
  logic [SAMPLE_BITS-1:0] out_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TRIM:  cfg.trim  <= cfg_data[TRIM_W-1:0];
        REG_PLUS:  cfg.plus  <= cfg_data[WGT_W-1:0];
        REG_MINUS: cfg.minus <= cfg_data[WGT_W-1:0];
        REG_WET:   cfg.wet   <= cfg_data[WET_W-1:0];
      endcase
    end
  end

  assign start          = in_frame.valid && idle;
  assign in_frame.ready = idle;
  assign res_take       = res_valid && (!out_valid || out_frame.ready);

  pwmd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .left_in   (in_frame.left_in),
    .right_in  (in_frame.right_in),
    .idle      (idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_left  (res_left),
    .res_right (res_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_left  <= res_left;
      out_right <= res_right;
    end
  end

  assign out_frame.valid     = out_valid;
  assign out_frame.left_out  = out_left;
  assign out_frame.right_out = out_right;

endmodule

/* sv/pwmd_checker.sv */
// ----------------------------------------------------------------------------
// pwmd_checker
// Port-level checks on frame flow, bound to the waveshaper top level.
// ----------------------------------------------------------------------------
`include "polynomial_waveshaper_mix_dither_assert.svh"

module pwmd_checker import pwmd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] left_out,
  input logic [SAMPLE_BITS-1:0] right_out
);

  `PWMD_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid, "output valid after reset")

  `PWMD_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready while busy")

  `PWMD_ASSERT(a_no_early_result,
               in_valid && in_ready && !out_valid |=> !out_valid,
               "early result")

  `PWMD_ASSERT(a_stall_holds,
               out_valid && !out_ready |=>
                 out_valid && $stable(left_out) && $stable(right_out),
               "stalled output changed")

endmodule

bind polynomial_waveshaper_mix_dither pwmd_checker u_pwmd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_frame.valid),
  .in_ready  (in_frame.ready),
  .out_valid (out_frame.valid),
  .out_ready (out_frame.ready),
  .left_out  (out_frame.left_out),
  .right_out (out_frame.right_out)
);
